[rtl/conditional_nesting_tracker_unit_defines.svh]
// Assertion macros for the conditional nesting tracker RTL
`ifndef CONDITIONAL_NESTING_TRACKER_UNIT_DEFINES_SVH
`define CONDITIONAL_NESTING_TRACKER_UNIT_DEFINES_SVH

// property that must hold at every rising clock edge out of reset
`define CNTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define CNTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cntu_pkg.sv]
// Types, constants and helpers for the conditional nesting tracker
`default_nettype none

package cntu_pkg;

  localparam int StackDepth = 32;
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int CfgW       = 5;
  localparam int OpenW      = 5;
  localparam int CmpW       = (CntW > CfgW + 1) ? CntW : CfgW + 1;
  localparam int OpenMax    = 31;
  localparam int MaxOpenRst = 16;

  typedef enum logic [2:0] {
    ST_TAKEN      = 3'd0,
    ST_TAKEN_ELSE = 3'd1,
    ST_NOT        = 3'd2,
    ST_NOT_ELSE   = 3'd3,
    ST_DEAD       = 3'd4
  } lvl_state_e;

  typedef enum logic [2:0] {
    MODE_IFNE = 3'd0,
    MODE_IFEQ = 3'd1,
    MODE_IFGT = 3'd2,
    MODE_IFLT = 3'd3,
    MODE_IFGE = 3'd4,
    MODE_IFLE = 3'd5,
    MODE_ELSE = 3'd6,
    MODE_ENDC = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_LIMIT      = 3'd1,
    ERR_ELSE_NO_IF = 3'd2,
    ERR_EXTRA_ELSE = 3'd3,
    ERR_ENDC_NO_IF = 3'd4,
    ERR_OVERFLOW   = 3'd5
  } err_e;

  typedef enum logic {
    CFG_STRICT   = 1'b0,
    CFG_MAX_OPEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_LOAD = 2'd3
  } shift_op_e;

  typedef struct packed {
    shift_op_e  op;
    lvl_state_e new_state;
  } stack_ctl_t;

  typedef struct packed {
    logic             skipping;
    logic [OpenW-1:0] open_levels;
    logic             label_error;
    err_e             error_code;
  } result_t;

  // lines are assembled only under these two states
  function automatic logic is_active(lvl_state_e s);
    return (s == ST_TAKEN) || (s == ST_NOT_ELSE);
  endfunction

endpackage

`default_nettype wire

[rtl/cntu_cell.sv]
// One level of the shift stack: holds, takes from above (push or load) or from below (pop)
`default_nettype none

module cntu_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cntu_pkg::shift_op_e op_i,
  input  cntu_pkg::lvl_state_e above_i,
  input  cntu_pkg::lvl_state_e below_i,
  output cntu_pkg::lvl_state_e state_o
);
  import cntu_pkg::*;

  lvl_state_e state_d, state_q;

  always_comb begin
    unique case (op_i)
      OP_HOLD: state_d = state_q;
      OP_PUSH: state_d = above_i;
      OP_LOAD: state_d = above_i;
      OP_POP:  state_d = below_i;
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKEN;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

[rtl/cntu_ctrl.sv]
// Directive decode, level counter, skip flag and configuration registers
`default_nettype none
`include "conditional_nesting_tracker_unit_defines.svh"

module cntu_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [2:0]                mode_i,
  input  logic [15:0]               operand_i,
  input  logic                      has_label_i,
  input  logic                      other_lock_i,
  input  cntu_pkg::lvl_state_e      top_i,
  input  cntu_pkg::lvl_state_e      next_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [cntu_pkg::CfgW-1:0] cfg_wdata_i,
  output cntu_pkg::stack_ctl_t      ctl_o,
  output cntu_pkg::result_t         res_o
);
  import cntu_pkg::*;

  logic [CntW-1:0] count_d, count_q;
  logic            skip_d, skip_q;
  logic            strict_q;
  logic [CfgW-1:0] max_open_q;

  mode_e           mode;
  stack_ctl_t      ctl;
  logic            test_hit;
  logic            neg, zero, full, base_only, at_limit;
  lvl_state_e      push_st;
  logic            lab_err;
  err_e            err;
  logic [CntW-1:0] open_full;

  assign mode      = mode_e'(mode_i);
  assign neg       = operand_i[15];
  assign zero      = (operand_i == 16'd0);
  assign full      = (count_q == CntW'(StackDepth));
  assign base_only = (count_q <= CntW'(1));
  assign at_limit  = strict_q &&
                     (CmpW'(count_q) == (CmpW'(max_open_q) + CmpW'(1)));

  always_comb begin
    unique case (mode)
      MODE_IFNE: test_hit = !zero;
      MODE_IFEQ: test_hit = zero;
      MODE_IFGT: test_hit = !neg && !zero;
      MODE_IFLT: test_hit = neg;
      MODE_IFGE: test_hit = !neg;
      MODE_IFLE: test_hit = neg || zero;
      default:   test_hit = 1'b0;
    endcase
  end

  assign push_st = is_active(top_i) ? (test_hit ? ST_TAKEN : ST_NOT) : ST_DEAD;

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.new_state = ST_DEAD;
    lab_err       = 1'b0;
    err           = ERR_NONE;
    count_d       = count_q;
    skip_d        = skip_q;
    case (mode) inside
      MODE_IFNE, MODE_IFEQ, MODE_IFGT, MODE_IFLT, MODE_IFGE, MODE_IFLE: begin
        if (other_lock_i || skip_q) begin
          // inside a skipped region only nesting is tracked
          if (skip_q) begin
            if (full) begin
              err = ERR_OVERFLOW;
            end else begin
              ctl.op  = OP_PUSH;
              count_d = count_q + CntW'(1);
            end
          end
        end else begin
          lab_err = has_label_i;
          if (at_limit) begin
            err = ERR_LIMIT;
          end else if (full) begin
            err    = ERR_OVERFLOW;
            skip_d = !is_active(top_i);
          end else begin
            ctl.op        = OP_PUSH;
            ctl.new_state = push_st;
            count_d       = count_q + CntW'(1);
            skip_d        = !is_active(push_st);
          end
        end
      end
      MODE_ELSE: begin
        if (!other_lock_i) begin
          lab_err = has_label_i;
          if (base_only) begin
            err = ERR_ELSE_NO_IF;
          end else if (top_i == ST_TAKEN_ELSE || top_i == ST_NOT_ELSE) begin
            err = ERR_EXTRA_ELSE;
          end else begin
            ctl.op = OP_LOAD;
            if (top_i == ST_TAKEN) begin
              ctl.new_state = ST_TAKEN_ELSE;
            end else if (top_i == ST_NOT) begin
              ctl.new_state = ST_NOT_ELSE;
            end else begin
              ctl.new_state = ST_DEAD;
            end
            skip_d = !is_active(ctl.new_state);
          end
        end
      end
      default: begin
        if (!other_lock_i) begin
          lab_err = has_label_i;
          if (base_only) begin
            err    = ERR_ENDC_NO_IF;
            skip_d = !is_active(top_i);
          end else begin
            ctl.op  = OP_POP;
            count_d = count_q - CntW'(1);
            skip_d  = !is_active(next_i);
          end
        end
      end
    endcase
  end

  assign open_full = count_d - CntW'(1);

  always_comb begin
    res_o.skipping    = skip_d;
    res_o.label_error = lab_err;
    res_o.error_code  = err;
    if (CmpW'(open_full) > CmpW'(OpenMax)) begin
      res_o.open_levels = OpenW'(OpenMax);
    end else begin
      res_o.open_levels = OpenW'(open_full);
    end
  end

  always_comb begin
    ctl_o    = ctl;
    ctl_o.op = accept_i ? ctl.op : OP_HOLD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
      skip_q  <= 1'b0;
    end else if (accept_i) begin
      count_q <= count_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q   <= 1'b1;
      max_open_q <= CfgW'(MaxOpenRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STRICT:   strict_q   <= cfg_wdata_i[0];
        CFG_MAX_OPEN: max_open_q <= cfg_wdata_i;
        default:      strict_q   <= strict_q;
      endcase
    end
  end

  `CNTU_ASSERT(a_count_range, (count_q != '0) && (count_q <= CntW'(StackDepth)), "level count out of range")
  `CNTU_ASSERT(a_skip_matches_top, skip_q == !is_active(top_i), "skip flag disagrees with stack top")
  `CNTU_ASSERT_NEXT(a_push_counts, ctl_o.op == OP_PUSH, count_q == $past(count_q) + CntW'(1), "push did not raise level count")
  `CNTU_ASSERT_NEXT(a_pop_counts, ctl_o.op == OP_POP, count_q == $past(count_q) - CntW'(1), "pop did not lower level count")
  `CNTU_ASSERT(a_overflow_when_full, !(accept_i && err == ERR_OVERFLOW) || full, "overflow reported below capacity")

endmodule

`default_nettype wire

[rtl/conditional_nesting_tracker_unit.sv]
// Top level: conditional nesting tracker with a shift-register level stack
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | mode, operand, has_label, other_lock
//   out     | output    | out_valid_o / out_stall_i| skipping, open_levels, label_error,
//           |           |                          | error_code
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the input is not stalled; each result appears in the cycle after its item is accepted.
// Level update: a row shift (on else a top rewrite) plus the counter, in the accept cycle.
// Input is stalled only while a result sits in the output register and out_stall_i is high.
// Reset leaves one taken base level, skip off, strict limit on, limit 16.
`default_nettype none

module conditional_nesting_tracker_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 mode_i,
  input  logic [15:0]                operand_i,
  input  logic                       has_label_i,
  input  logic                       other_lock_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       skipping_o,
  output logic [cntu_pkg::OpenW-1:0] open_levels_o,
  output logic                       label_error_o,
  output logic [2:0]                 error_code_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cntu_pkg::CfgW-1:0]  cfg_wdata_i
);
  import cntu_pkg::*;

  logic       accept;
  logic       out_valid_d, out_valid_q;
  stack_ctl_t ctl;
  result_t    res, res_q;
  lvl_state_e cell_state [StackDepth];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  cntu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .operand_i    (operand_i),
    .has_label_i  (has_label_i),
    .other_lock_i (other_lock_i),
    .top_i        (cell_state[0]),
    .next_i       (cell_state[1]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .ctl_o        (ctl),
    .res_o        (res)
  );

  // cell 0 is the stack top; only it takes a rewrite on else
  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    shift_op_e  op;
    lvl_state_e above, below;

    if (i == 0) begin : g_top
      assign op    = ctl.op;
      assign above = ctl.new_state;
    end else begin : g_mid
      assign op    = (ctl.op == OP_LOAD) ? OP_HOLD : ctl.op;
      assign above = cell_state[i-1];
    end

    if (i == StackDepth - 1) begin : g_last
      assign below = ST_DEAD;
    end else begin : g_link
      assign below = cell_state[i+1];
    end

    cntu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .state_o (cell_state[i])
    );
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign skipping_o    = res_q.skipping;
  assign open_levels_o = res_q.open_levels;
  assign label_error_o = res_q.label_error;
  assign error_code_o  = res_q.error_code;

endmodule

`default_nettype wire

[tb/sv/conditional_nesting_tracker_unit_test.sv]
// Self-checking testbench for the conditional nesting tracker unit
`timescale 1ns / 100ps

module conditional_nesting_tracker_unit_test;
  import cntu_pkg::*;

  localparam int IdxW = $clog2(StackDepth);

  typedef struct packed {
    mode_e       mode;
    logic [15:0] operand;
    logic        has_label;
    logic        other_lock;
  } directive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       mode = MODE_IFNE;
  logic [15:0]      operand = 16'h0;
  logic             has_label = 1'b0;
  logic             other_lock = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             skipping;
  logic [OpenW-1:0] open_levels;
  logic             label_error;
  logic [2:0]       error_code;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = 1'b0;
  logic [CfgW-1:0]  cfg_wdata = '0;

  directive_t pending_q[$];
  result_t    expected_q[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         mismatch_cnt = 0;

  // predictor state: level stack, entry count, skip flag, registers
  lvl_state_e      lvl_q [StackDepth];
  logic [CntW-1:0] depth_q = CntW'(1);
  logic            skip_q = 1'b0;
  logic            strict_q = 1'b1;
  logic [CfgW-1:0] max_open_q = CfgW'(MaxOpenRst);

  conditional_nesting_tracker_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .operand_i     (operand),
    .has_label_i   (has_label),
    .other_lock_i  (other_lock),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .skipping_o    (skipping),
    .open_levels_o (open_levels),
    .label_error_o (label_error),
    .error_code_o  (error_code),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic top_is_active();
    lvl_state_e s;
    s = lvl_q[IdxW'(depth_q - 1'b1)];
    return (s == ST_TAKEN) || (s == ST_NOT_ELSE);
  endfunction

  function automatic err_e push_level(lvl_state_e s);
    if (depth_q >= StackDepth) return ERR_OVERFLOW;
    lvl_q[depth_q[IdxW-1:0]] = s;
    depth_q = depth_q + 1'b1;
    return ERR_NONE;
  endfunction

  function automatic result_t predict_directive(directive_t d);
    result_t    r;
    logic       neg;
    logic       zero;
    logic       hit;
    lvl_state_e s;
    r.label_error = 1'b0;
    r.error_code  = ERR_NONE;
    neg  = d.operand[15];
    zero = (d.operand == 16'h0);
    if (d.mode <= MODE_IFLE) begin
      if (d.other_lock || skip_q) begin
        // nothing tested; inside a skipped region the level is still tracked
        if (skip_q) r.error_code = push_level(ST_DEAD);
      end else begin
        r.label_error = d.has_label;
        if (strict_q && depth_q == {1'b0, max_open_q} + 1'b1) begin
          r.error_code = ERR_LIMIT;
        end else begin
          case (d.mode)
            MODE_IFNE: hit = !zero;
            MODE_IFEQ: hit = zero;
            MODE_IFGT: hit = !neg && !zero;
            MODE_IFLT: hit = neg;
            MODE_IFGE: hit = !neg;
            default:   hit = neg || zero;
          endcase
          if (top_is_active()) r.error_code = push_level(hit ? ST_TAKEN : ST_NOT);
          else r.error_code = push_level(ST_DEAD);
          skip_q = !top_is_active();
        end
      end
    end else if (!d.other_lock) begin
      r.label_error = d.has_label;
      if (d.mode == MODE_ELSE) begin
        if (depth_q <= 1) begin
          r.error_code = ERR_ELSE_NO_IF;
        end else begin
          s = lvl_q[IdxW'(depth_q - 1'b1)];
          if (s == ST_TAKEN_ELSE || s == ST_NOT_ELSE) begin
            r.error_code = ERR_EXTRA_ELSE;
          end else begin
            if (s == ST_TAKEN) lvl_q[IdxW'(depth_q - 1'b1)] = ST_TAKEN_ELSE;
            else if (s == ST_NOT) lvl_q[IdxW'(depth_q - 1'b1)] = ST_NOT_ELSE;
            skip_q = !top_is_active();
          end
        end
      end else begin
        if (depth_q <= 1) r.error_code = ERR_ENDC_NO_IF;
        else depth_q = depth_q - 1'b1;
        skip_q = !top_is_active();
      end
    end
    r.skipping    = skip_q;
    r.open_levels = OpenW'(depth_q - 1'b1);
    return r;
  endfunction

  function automatic void queue_directive(mode_e m, logic [15:0] opnd, logic lab, logic lock);
    directive_t d;
    d.mode       = m;
    d.operand    = opnd;
    d.has_label  = lab;
    d.other_lock = lock;
    pending_q.push_back(d);
  endfunction

  // bursts with a varying push bias so the stack climbs to capacity and drains again
  task automatic queue_random(int n);
    int          left;
    int          burst;
    int          push_w;
    int          r;
    int          sel;
    mode_e       m;
    logic [15:0] opnd;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       push_w = 25;
        1:       push_w = 50;
        2:       push_w = 75;
        default: push_w = 95;
      endcase
      while (burst > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        if (r < push_w) m = mode_e'($urandom_range(0, 5));
        else if (r < push_w + (100 - push_w) / 4) m = MODE_ELSE;
        else m = MODE_ENDC;
        sel = $urandom_range(0, 5);
        case (sel)
          0:       opnd = 16'h0000;
          1:       opnd = 16'h8000;
          2:       opnd = 16'h7fff;
          3:       opnd = 16'hffff;
          default: opnd = 16'($urandom_range(0, 65535));
        endcase
        queue_directive(m, opnd, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        burst--;
        left--;
      end
    end
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_STRICT) strict_q = val[0];
    else max_open_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
  endtask

  // driver: payload held until accepted; prediction happens at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_directive(pending_q.pop_front()));
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        mode       <= pending_q[0].mode;
        operand    <= pending_q[0].operand;
        has_label  <= pending_q[0].has_label;
        other_lock <= pending_q[0].other_lock;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result skip=%0b open=%0d lab=%0b err=%0d", $realtime,
                     skipping, open_levels, label_error, error_code);
        end else begin
          e = expected_q.pop_front();
          if (skipping !== e.skipping || open_levels !== e.open_levels ||
              label_error !== e.label_error || error_code !== e.error_code) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: mismatch exp skip=%0b open=%0d lab=%0b err=%0d, ",
                        "got skip=%0b open=%0d lab=%0b err=%0d"},
                       $realtime, e.skipping, e.open_levels, e.label_error, e.error_code,
                       skipping, open_levels, label_error, error_code);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    logic [CfgW-1:0] strict_val [6];
    logic [CfgW-1:0] max_val [6];
    strict_val = '{5'd0, 5'd1, 5'h1f, 5'd1, 5'h1e, 5'd1};
    max_val    = '{5'd31, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16};
    lvl_q[0] = ST_TAKEN;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: misplaced else/endc, every test, locked and dead levels
    queue_directive(MODE_ELSE, 16'h0000, 1'b1, 1'b0);
    queue_directive(MODE_ENDC, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_IFNE, 16'h0000, 1'b1, 1'b0);
    queue_directive(MODE_ELSE, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_ELSE, 16'h0000, 1'b1, 1'b0);
    queue_directive(MODE_IFGT, 16'h7fff, 1'b0, 1'b0);
    queue_directive(MODE_IFLT, 16'h8000, 1'b0, 1'b0);
    queue_directive(MODE_IFGE, 16'hffff, 1'b0, 1'b0);
    queue_directive(MODE_IFLE, 16'h0000, 1'b0, 1'b1);
    queue_directive(MODE_IFEQ, 16'hffff, 1'b1, 1'b0);
    queue_directive(MODE_ELSE, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_ENDC, 16'h0000, 1'b1, 1'b1);
    queue_directive(MODE_ENDC, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_ENDC, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_ELSE, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_ENDC, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_IFEQ, 16'h0000, 1'b1, 1'b1);
    queue_directive(MODE_IFEQ, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_IFLE, 16'h8000, 1'b0, 1'b0);
    queue_directive(MODE_IFGT, 16'h0000, 1'b0, 1'b0);
    queue_directive(MODE_IFGT, 16'h0001, 1'b0, 1'b0);
    queue_directive(MODE_ELSE, 16'h0000, 1'b1, 1'b1);
    queue_directive(MODE_IFNE, 16'hffff, 1'b0, 1'b0);
    queue_random(250);

    for (int ph = 1; ph < 7; ph++) begin
      wait_drained();
      write_register(CFG_STRICT, strict_val[ph-1]);
      write_register(CFG_MAX_OPEN, max_val[ph-1]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 87; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      queue_random(250);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("[conditional_nesting_tracker_unit] OK");
    end else begin
      $display("[conditional_nesting_tracker_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[conditional_nesting_tracker_unit] ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/cntu_pkg.sv
rtl/cntu_cell.sv
rtl/cntu_ctrl.sv
rtl/conditional_nesting_tracker_unit.sv
tb/sv/conditional_nesting_tracker_unit_test.sv
